[design/sequence_counter_gap_monitor_defines.svh]
// ---------------------------------------------------------------------------
// Sequence counter gap monitor: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SEQUENCE_COUNTER_GAP_MONITOR_DEFINES_SVH
`define SEQUENCE_COUNTER_GAP_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/scgm_pkg.sv]
// ---------------------------------------------------------------------------
// Sequence counter gap monitor package
// Word types, field widths and opcodes shared by the monitor's files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scgm_pkg;

  localparam int SEQ_BITS       = 8;
  localparam int BIN_COUNT      = 256;
  localparam int OUT_COUNT_BITS = 32;
  localparam int PORT_TIME_BITS = 48;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic [SEQ_BITS-1:0]       seq_value;
    logic [PORT_TIME_BITS-1:0] arrival_ns;
    logic [SEQ_BITS-1:0]       bin_select;
  } item_word_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]       delta;
    logic                      delta_valid;
    logic [PORT_TIME_BITS-1:0] gap_ns;
    logic [OUT_COUNT_BITS-1:0] bin_count;
    logic [OUT_COUNT_BITS-1:0] frames_seen;
    logic [OUT_COUNT_BITS-1:0] same_count;
    logic [OUT_COUNT_BITS-1:0] step_count;
    logic [OUT_COUNT_BITS-1:0] jump_count;
    logic [OUT_COUNT_BITS-1:0] missing_total;
    logic [SEQ_BITS-1:0]       first_seq;
    logic [PORT_TIME_BITS-1:0] max_gap_ns;
  } result_word_t;

endpackage

[design/scgm_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/sequence_counter_gap_monitor.sv]
// ---------------------------------------------------------------------------
// Sequence counter gap monitor
// Audits an 8-bit frame counter: delta histogram, delta classes, missing
// frames and inter-frame gap with running maximum.
// ---------------------------------------------------------------------------
// For each word the histogram memory is read in the cycle the word is
// accepted; the bin is updated and written back once the output register is
// free, in the same cycle the result is loaded into it. A new word is
// accepted while a finished result still waits there. The histogram is
// cleared at reset through one valid flip-flop per bin, so no clearing pass
// is needed. Counters and bins saturate at all ones of COUNT_BITS.
`timescale 1ns / 1ps
`include "sequence_counter_gap_monitor_defines.svh"

module sequence_counter_gap_monitor
  import scgm_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  item_word_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [SEQ_BITS-1:0]   b);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + {{(COUNT_BITS + 1 - SEQ_BITS){1'b0}}, b};
    if (sum >= {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  function automatic logic [OUT_COUNT_BITS-1:0] count_out(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_COUNT_BITS-1:0];
  endfunction

  function automatic logic [PORT_TIME_BITS-1:0] time_out(input logic [TIME_BITS-1:0] t);
    logic [63:0] w;
    w = 64'(t);
    return w[PORT_TIME_BITS-1:0];
  endfunction

  localparam logic [SEQ_BITS-1:0] ONE_SEQ = SEQ_BITS'(1);

  // Statistics state.
  logic                  have_previous, have_previous_next;
  logic [SEQ_BITS-1:0]   previous_seq, previous_seq_next;
  logic [TIME_BITS-1:0]  previous_time, previous_time_next;
  logic [SEQ_BITS-1:0]   first_seen_seq, first_seen_seq_next;
  logic [COUNT_BITS-1:0] frame_total, frame_total_next;
  logic [COUNT_BITS-1:0] zero_delta_total, zero_delta_total_next;
  logic [COUNT_BITS-1:0] unit_delta_total, unit_delta_total_next;
  logic [COUNT_BITS-1:0] big_delta_total, big_delta_total_next;
  logic [COUNT_BITS-1:0] lost_total, lost_total_next;
  logic [TIME_BITS-1:0]  largest_gap, largest_gap_next;
  logic [BIN_COUNT-1:0]  bin_written;

  // Word in flight.
  logic                  busy;
  logic                  cur_op;
  logic [SEQ_BITS-1:0]   cur_seq;
  logic [SEQ_BITS-1:0]   cur_delta;
  logic [TIME_BITS-1:0]  cur_time;
  logic                  cur_hit;

  logic                  accept;
  logic                  done;
  logic [SEQ_BITS-1:0]   delta_in;
  logic [SEQ_BITS-1:0]   rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] bin_cur;
  logic                  hist_wr;
  logic [COUNT_BITS-1:0] hist_wr_data;
  logic                  is_record;
  logic                  boundary;
  logic [TIME_BITS-1:0]  gap;
  result_word_t          result_next;

  assign accept     = item_valid && !busy;
  assign item_stall = busy;
  assign done       = busy && (!result_valid || !result_stall);

  assign delta_in = item.seq_value - previous_seq;
  assign rd_addr  = (item.opcode == OP_READ) ? item.bin_select : delta_in;

  assign bin_cur      = cur_hit ? rd_data : '0;
  assign is_record    = (cur_op == OP_RECORD);
  assign boundary     = is_record && have_previous;
  assign gap          = cur_time - previous_time;
  assign hist_wr      = done && boundary;
  assign hist_wr_data = sat_add(bin_cur, ONE_SEQ);

  scgm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_wr),
    .wr_addr (cur_delta),
    .wr_data (hist_wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    have_previous_next    = have_previous;
    previous_seq_next     = previous_seq;
    previous_time_next    = previous_time;
    first_seen_seq_next   = first_seen_seq;
    frame_total_next      = frame_total;
    zero_delta_total_next = zero_delta_total;
    unit_delta_total_next = unit_delta_total;
    big_delta_total_next  = big_delta_total;
    lost_total_next       = lost_total;
    largest_gap_next      = largest_gap;
    if (done && is_record) begin
      if (have_previous) begin
        if (cur_delta == '0) begin
          zero_delta_total_next = sat_add(zero_delta_total, ONE_SEQ);
        end else if (cur_delta == ONE_SEQ) begin
          unit_delta_total_next = sat_add(unit_delta_total, ONE_SEQ);
        end else begin
          big_delta_total_next = sat_add(big_delta_total, ONE_SEQ);
          lost_total_next      = sat_add(lost_total, cur_delta - ONE_SEQ);
        end
        if (gap > largest_gap) begin
          largest_gap_next = gap;
        end
      end else begin
        first_seen_seq_next = cur_seq;
      end
      have_previous_next = 1'b1;
      previous_seq_next  = cur_seq;
      previous_time_next = cur_time;
      frame_total_next   = sat_add(frame_total, ONE_SEQ);
    end
  end

  always_comb begin
    result_next.delta         = boundary ? cur_delta : '0;
    result_next.delta_valid   = boundary;
    result_next.gap_ns        = boundary ? time_out(gap) : '0;
    result_next.bin_count     = is_record ? '0 : count_out(bin_cur);
    result_next.frames_seen   = count_out(frame_total_next);
    result_next.same_count    = count_out(zero_delta_total_next);
    result_next.step_count    = count_out(unit_delta_total_next);
    result_next.jump_count    = count_out(big_delta_total_next);
    result_next.missing_total = count_out(lost_total_next);
    result_next.first_seq     = first_seen_seq_next;
    result_next.max_gap_ns    = time_out(largest_gap_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous    <= 1'b0;
      previous_seq     <= '0;
      previous_time    <= '0;
      first_seen_seq   <= '0;
      frame_total      <= '0;
      zero_delta_total <= '0;
      unit_delta_total <= '0;
      big_delta_total  <= '0;
      lost_total       <= '0;
      largest_gap      <= '0;
      bin_written      <= '0;
      busy             <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      have_previous    <= have_previous_next;
      previous_seq     <= previous_seq_next;
      previous_time    <= previous_time_next;
      first_seen_seq   <= first_seen_seq_next;
      frame_total      <= frame_total_next;
      zero_delta_total <= zero_delta_total_next;
      unit_delta_total <= unit_delta_total_next;
      big_delta_total  <= big_delta_total_next;
      lost_total       <= lost_total_next;
      largest_gap      <= largest_gap_next;
      if (hist_wr) begin
        bin_written[cur_delta] <= 1'b1;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op    <= item.opcode;
      cur_seq   <= item.seq_value;
      cur_delta <= delta_in;
      cur_time  <= TIME_BITS'(item.arrival_ns);
      cur_hit   <= bin_written[rd_addr];
    end
    if (done) begin
      result <= result_next;
    end
  end

  `SCGM_ASSERT_NOW(a_first_frame_zero,
    result_valid && !result.delta_valid,
    result.delta == '0 && result.gap_ns == '0,
    "result without a previous frame carries a delta or gap")
  `SCGM_ASSERT_NOW(a_hist_write_after_first,
    hist_wr,
    have_previous && busy,
    "histogram written without a previous frame")
  `SCGM_ASSERT_NEXT(a_done_loads_result,
    done,
    result_valid && !busy,
    "finished word did not reach the output register")

endmodule

[verif/gap_monitor_checker.sv]
// ---------------------------------------------------------------------------
// Sequence counter gap monitor: result checker
// Watches both channels of the monitor. Every accepted input word updates
// a private copy of the monitor state and queues the statistics word it
// should produce; every accepted result word is compared field by field
// with the oldest queued one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_monitor_checker
  import scgm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_stall,
  input  item_word_t   item,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_word_t result,
  output int           mismatch_count,
  output int           pending_words,
  output int           words_checked
);

  localparam logic [OUT_COUNT_BITS-1:0] COUNT_TOP = '1;

  logic                      have_prev;
  logic [SEQ_BITS-1:0]       prev_seq;
  logic [PORT_TIME_BITS-1:0] prev_time;
  logic [SEQ_BITS-1:0]       first_seq_seen;
  logic [OUT_COUNT_BITS-1:0] frame_total;
  logic [OUT_COUNT_BITS-1:0] zero_total;
  logic [OUT_COUNT_BITS-1:0] unit_total;
  logic [OUT_COUNT_BITS-1:0] jump_total;
  logic [OUT_COUNT_BITS-1:0] lost_total;
  logic [PORT_TIME_BITS-1:0] widest_gap;
  logic [OUT_COUNT_BITS-1:0] delta_bins [BIN_COUNT];
  result_word_t              expected_stats [$];

  function automatic logic [OUT_COUNT_BITS-1:0] add_sticky(
    logic [OUT_COUNT_BITS-1:0] a, logic [OUT_COUNT_BITS-1:0] b);
    if (b >= COUNT_TOP - a) return COUNT_TOP;
    return a + b;
  endfunction

  function automatic result_word_t apply_word(item_word_t w);
    result_word_t              r;
    logic [SEQ_BITS-1:0]       d;
    logic [PORT_TIME_BITS-1:0] g;
    r = '0;
    if (w.opcode == OP_READ) begin
      r.bin_count = delta_bins[w.bin_select];
    end else begin
      if (have_prev) begin
        d = w.seq_value - prev_seq;
        g = w.arrival_ns - prev_time;
        r.delta = d;
        r.delta_valid = 1'b1;
        r.gap_ns = g;
        delta_bins[d] = add_sticky(delta_bins[d], 1);
        if (d == 0) begin
          zero_total = add_sticky(zero_total, 1);
        end else if (d == 1) begin
          unit_total = add_sticky(unit_total, 1);
        end else begin
          jump_total = add_sticky(jump_total, 1);
          lost_total = add_sticky(lost_total, OUT_COUNT_BITS'(d) - 1);
        end
        if (g > widest_gap) widest_gap = g;
      end else begin
        first_seq_seen = w.seq_value;
      end
      have_prev = 1'b1;
      prev_seq = w.seq_value;
      prev_time = w.arrival_ns;
      frame_total = add_sticky(frame_total, 1);
    end
    r.frames_seen = frame_total;
    r.same_count = zero_total;
    r.step_count = unit_total;
    r.jump_count = jump_total;
    r.missing_total = lost_total;
    r.first_seq = first_seq_seen;
    r.max_gap_ns = widest_gap;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      have_prev = 1'b0;
      prev_seq = '0;
      prev_time = '0;
      first_seq_seen = '0;
      frame_total = '0;
      zero_total = '0;
      unit_total = '0;
      jump_total = '0;
      lost_total = '0;
      widest_gap = '0;
      for (int i = 0; i < BIN_COUNT; i++) delta_bins[i] = '0;
      expected_stats.delete();
      mismatch_count = 0;
      words_checked = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: result word expected none, got %h", $time, result);
          mismatch_count++;
        end else begin
          want = expected_stats.pop_front();
          check_field("delta", 64'(want.delta), 64'(result.delta));
          check_field("delta_valid", 64'(want.delta_valid), 64'(result.delta_valid));
          check_field("gap_ns", 64'(want.gap_ns), 64'(result.gap_ns));
          check_field("bin_count", 64'(want.bin_count), 64'(result.bin_count));
          check_field("frames_seen", 64'(want.frames_seen), 64'(result.frames_seen));
          check_field("same_count", 64'(want.same_count), 64'(result.same_count));
          check_field("step_count", 64'(want.step_count), 64'(result.step_count));
          check_field("jump_count", 64'(want.jump_count), 64'(result.jump_count));
          check_field("missing_total", 64'(want.missing_total),
                      64'(result.missing_total));
          check_field("first_seq", 64'(want.first_seq), 64'(result.first_seq));
          check_field("max_gap_ns", 64'(want.max_gap_ns), 64'(result.max_gap_ns));
          words_checked++;
        end
      end
      if (item_valid && !item_stall) expected_stats.push_back(apply_word(item));
    end
    pending_words <= expected_stats.size();
  end

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// Sequence counter gap monitor testbench
// Drives frame and bin-read words into the monitor with random idling on
// both channels: a directed opening for wraps, duplicates, large jumps and
// timestamps at their extremes, then long runs of mostly in-order frames
// with drops, repeats, bin reads and odd timestamps mixed in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scgm_pkg::*;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 300;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_stall;
  item_word_t   item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result;

  int  mismatch_count;
  int  pending_words;
  int  words_checked;
  int  frames_sent = 0;
  int  reads_sent = 0;
  bit  calm = 1'b0;

  logic [SEQ_BITS-1:0]       seq_cursor;
  logic [PORT_TIME_BITS-1:0] time_cursor;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sequence_counter_gap_monitor uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  gap_monitor_checker stats_check (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words),
    .words_checked  (words_checked)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PORT_TIME_BITS-1:0] random_time();
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    return r64[PORT_TIME_BITS-1:0];
  endfunction

  task automatic send_word(input item_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (w.opcode == OP_READ) reads_sent++;
    else frames_sent++;
  endtask

  task automatic send_frame(input logic [SEQ_BITS-1:0] s,
                            input logic [PORT_TIME_BITS-1:0] t);
    item_word_t w;
    w.opcode = OP_RECORD;
    w.seq_value = s;
    w.arrival_ns = t;
    w.bin_select = SEQ_BITS'($urandom_range(0, 255));
    send_word(w);
  endtask

  task automatic send_read(input logic [SEQ_BITS-1:0] b);
    item_word_t w;
    w.opcode = OP_READ;
    w.seq_value = SEQ_BITS'($urandom_range(0, 255));
    w.arrival_ns = random_time();
    w.bin_select = b;
    send_word(w);
  endtask

  task automatic send_random_word();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_read(SEQ_BITS'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, 255)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) seq_cursor = SEQ_BITS'(seq_cursor + 1);
      else if (r < 92 && r >= 78) seq_cursor = SEQ_BITS'(seq_cursor + $urandom_range(2, 6));
      else if (r < 97 && r >= 92) seq_cursor = SEQ_BITS'(seq_cursor + $urandom_range(0, 255));
      else if (r >= 97) seq_cursor = SEQ_BITS'($urandom_range(0, 255));
      t = $urandom_range(0, 99);
      if (t < 80) time_cursor = time_cursor + $urandom_range(0, 400);
      else if (t < 92) time_cursor = time_cursor + $urandom_range(1000, 100000);
      else if (t < 96) time_cursor = time_cursor + $urandom;
      else if (t < 98) time_cursor = time_cursor - $urandom_range(1, 500);
      else time_cursor = random_time();
      send_frame(seq_cursor, time_cursor);
    end
  endtask

  initial begin
    int run;
    int hold;
    @(posedge clk);
    forever begin
      run = calm ? $urandom_range(20, 60) : $urandom_range(1, 10);
      result_stall <= 1'b0;
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    item_word_t w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_read(8'h00);
    send_read(8'hFF);
    send_frame(8'hFF, 48'd1000);
    send_frame(8'h00, 48'd1005);
    send_frame(8'h00, 48'd1005);
    send_frame(8'hFF, 48'd900000);
    send_frame(8'h7E, 48'd900100);
    send_frame(8'h7F, 48'd900000);
    send_frame(8'h81, 48'hFFFF_FFFF_FFFF);
    send_frame(8'h82, 48'h0000_0000_0000);
    send_frame(8'h55, 48'h5555_5555_5555);
    send_frame(8'hAA, 48'hAAAA_AAAA_AAAA);
    send_read(8'h00);
    send_read(8'h01);
    send_read(8'h02);
    send_read(8'hFF);
    send_read(8'h7F);
    send_read(8'hD3);
    send_read(8'h55);
    w.opcode = OP_READ;
    w.seq_value = 8'hFF;
    w.arrival_ns = '1;
    w.bin_select = 8'hFF;
    send_word(w);
    send_word('0);
    send_read(8'hAB);

    seq_cursor = 8'h00;
    time_cursor = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p % 3 == 1);
      for (int i = 0; i < PHASE_WORDS; i++) send_random_word();
    end
    calm = 1'b0;
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d frame words and %0d bin reads; %0d result words compared.",
             frames_sent, reads_sent, words_checked);
    $display("Covered counter wrap, repeats, jumps, backward and extreme timestamps.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
